// ===== design/ctprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctprt_pkg
// Constants and register codes for the crank tooth period and speed tracker.
// ----------------------------------------------------------------------------
package ctprt_pkg;

   // capture counter and field widths
   localparam int COUNTER_WIDTH = 16;
   localparam int PERIOD_W      = 24;
   localparam int RPM_W         = 16;
   localparam int TOOTH_W       = 16;
   localparam int SHIFT_W       = 3;
   localparam int CLOCK_W       = 27;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = CLOCK_W;

   // shifted tick count and scaled numerator
   localparam int TICKS_SH_W    = COUNTER_WIDTH + (1 << SHIFT_W) - 1;
   localparam int US_SCALE_W    = 20;
   localparam int MUL_A_W       = (TICKS_SH_W > PERIOD_W) ? TICKS_SH_W : PERIOD_W;
   localparam int MUL_B_W       = (US_SCALE_W > TOOTH_W) ? US_SCALE_W : TOOTH_W;
   localparam int PROD_W        = MUL_A_W + MUL_B_W;

   // shared divider
   localparam int DVD_W         = TICKS_SH_W + US_SCALE_W;
   localparam int DVS_W         = PERIOD_W + TOOTH_W;
   localparam int REM_W         = DVS_W + 1;
   localparam int RPM_Q_W       = 26;
   localparam int DIV_CNT_W     = $clog2(DVD_W + 1);

   localparam logic [DIV_CNT_W-1:0] PERIOD_STEPS = DIV_CNT_W'(DVD_W);
   localparam logic [DIV_CNT_W-1:0] RPM_STEPS    = DIV_CNT_W'(RPM_Q_W);

   localparam logic [US_SCALE_W-1:0] US_PER_SECOND = US_SCALE_W'(1000000);
   localparam logic [RPM_Q_W-1:0]    US_PER_MINUTE = RPM_Q_W'(60000000);
   localparam logic [RPM_W-1:0]      RPM_MAX       = 16'hFFFF;
   localparam logic [RPM_W-1:0]      RPM_SYNC_LOW  = 16'd100;
   localparam logic [RPM_W-1:0]      RPM_SYNC_HIGH = 16'd10000;
   localparam logic [PERIOD_W-1:0]   PERIOD_MAX    = 24'hFFFFFF;

   // register reset values
   localparam logic [TOOTH_W-1:0]       TEETH_RESET   = 16'd36;
   localparam logic [COUNTER_WIDTH-1:0] MODULUS_RESET = 16'hFFFF;
   localparam logic [SHIFT_W-1:0]       SHIFT_RESET   = 3'd0;
   localparam logic [CLOCK_W-1:0]       CLOCK_RESET   = 27'd60000000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEETH_PER_REV   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_MODULUS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESCALE_SHIFT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_CLOCK_HZ    = 2'd3;

   localparam int RSP_FIELDS_W = PERIOD_W + RPM_W + TOOTH_W + 1 + RPM_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== design/crank_tooth_period_rpm_tracker_top.sv =====
`timescale 1ns / 1ps
// Each input transfer passes through a multiply, the period divide steps, a multiply,
// the speed divide steps and a load into the output register. A new input is taken
// only in idle, after the last result is loaded; the single shared restoring divider sets the pace.
// Fewer cycles when the timer clock, period or tooth count is zero; more while a
// finished result waits for the output register. Reset (synchronous, active high)
// restores register defaults, clears capture, tooth index, sync and output valid.
// ----------------------------------------------------------------------------
// crank_tooth_period_rpm_tracker_top
// Tooth period in microseconds, engine speed, tooth index and sync tracking
// from crank tooth capture values, using one shared multiplier and divider.
// ----------------------------------------------------------------------------
module crank_tooth_period_rpm_tracker_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // capture_value [15:0]
   input  logic [ctprt_pkg::COUNTER_WIDTH-1:0]   req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // period_us [23:0], rpm_raw [39:24], tooth_index [55:40], sync_locked [56],
   // rpm_reported [72:57], zero [79:73]
   output logic [ctprt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wr_en,
   input  logic [ctprt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ctprt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ctprt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PERIOD,
      ST_DIV_PERIOD,
      ST_MUL_RPM,
      ST_DIV_RPM,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;

   logic [TOOTH_W-1:0]       teeth_ff, teeth_in;
   logic [COUNTER_WIDTH-1:0] modulus_ff, modulus_in;
   logic [SHIFT_W-1:0]       shift_ff, shift_in;
   logic [CLOCK_W-1:0]       clock_hz_ff, clock_hz_in;

   logic [COUNTER_WIDTH-1:0] prev_ff, prev_in;
   logic [TOOTH_W-1:0]       tooth_ff, tooth_in;
   logic                     sync_ff, sync_in;

   logic [COUNTER_WIDTH-1:0] ticks_ff, ticks_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic [RPM_W-1:0]         rpm_ff, rpm_in;

   logic [DVD_W-1:0]         dvd_ff, dvd_in;
   logic [DVS_W-1:0]         dvs_ff, dvs_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // tick distance
   logic [COUNTER_WIDTH+1:0] span;
   logic [COUNTER_WIDTH-1:0] ticks_new;
   logic [TOOTH_W-1:0]       tooth_next;

   // shared multiplier
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [PROD_W-1:0]        prod;
   logic [TICKS_SH_W-1:0]    ticks_sh;

   // shared divider step
   logic [REM_W-1:0]         rem_sh;
   logic                     q_bit;
   logic [DVD_W-1:0]         dvd_step;
   logic [REM_W-1:0]         rem_step;
   logic                     div_last;

   logic [RPM_W-1:0]         rpm_sat;
   logic                     sync_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      span = {2'b00, modulus_ff} + (COUNTER_WIDTH+2)'(1) + {2'b00, req_tdata};
      if (req_tdata >= prev_ff) begin
         ticks_new = req_tdata - prev_ff;
      end else if (span < {2'b00, prev_ff}) begin
         ticks_new = '0;
      end else begin
         ticks_new = COUNTER_WIDTH'(span - {2'b00, prev_ff});
      end
      tooth_next = tooth_ff + TOOTH_W'(1);
      if (tooth_next >= teeth_ff) begin
         tooth_next = '0;
      end
   end

   always_comb begin
      ticks_sh = TICKS_SH_W'(ticks_ff) << shift_ff;
      if (state_ff == ST_MUL_PERIOD) begin
         mul_a = MUL_A_W'(ticks_sh);
         mul_b = MUL_B_W'(US_PER_SECOND);
      end else begin
         mul_a = MUL_A_W'(period_ff);
         mul_b = MUL_B_W'(teeth_ff);
      end
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // one restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      rem_sh   = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
      q_bit    = (rem_sh >= {1'b0, dvs_ff});
      rem_step = q_bit ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
      dvd_step = {dvd_ff[DVD_W-2:0], q_bit};
      div_last = (cnt_ff == DIV_CNT_W'(1));
   end

   always_comb begin
      if (dvd_step[DVD_W-1:RPM_W] != '0) begin
         rpm_sat = RPM_MAX;
      end else begin
         rpm_sat = dvd_step[RPM_W-1:0];
      end
      sync_next = sync_ff || ((rpm_ff > RPM_SYNC_LOW) && (rpm_ff < RPM_SYNC_HIGH));
   end

   always_comb begin
      state_in     = state_ff;
      teeth_in     = teeth_ff;
      modulus_in   = modulus_ff;
      shift_in     = shift_ff;
      clock_hz_in  = clock_hz_ff;
      prev_in      = prev_ff;
      tooth_in     = tooth_ff;
      sync_in      = sync_ff;
      ticks_in     = ticks_ff;
      period_in    = period_ff;
      rpm_in       = rpm_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_TEETH_PER_REV:   teeth_in    = csr_wdata[TOOTH_W-1:0];
            CSR_COUNTER_MODULUS: modulus_in  = csr_wdata[COUNTER_WIDTH-1:0];
            CSR_PRESCALE_SHIFT:  shift_in    = csr_wdata[SHIFT_W-1:0];
            CSR_BUS_CLOCK_HZ:    clock_hz_in = csr_wdata[CLOCK_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ticks_in = ticks_new;
               prev_in  = req_tdata;
               tooth_in = tooth_next;
               state_in = ST_MUL_PERIOD;
            end
         end
         ST_MUL_PERIOD: begin
            if (clock_hz_ff == '0) begin
               period_in = '0;
               state_in  = ST_MUL_RPM;
            end else begin
               dvd_in   = prod[DVD_W-1:0];
               dvs_in   = DVS_W'(clock_hz_ff);
               rem_in   = '0;
               cnt_in   = PERIOD_STEPS;
               state_in = ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - DIV_CNT_W'(1);
            if (div_last) begin
               if (dvd_step[DVD_W-1:PERIOD_W] != '0) begin
                  period_in = PERIOD_MAX;
               end else begin
                  period_in = dvd_step[PERIOD_W-1:0];
               end
               state_in = ST_MUL_RPM;
            end
         end
         ST_MUL_RPM: begin
            if ((period_ff == '0) || (teeth_ff == '0)) begin
               rpm_in   = '0;
               state_in = ST_DONE;
            end else begin
               // dividend sits at the top so the quotient lands after fewer steps
               dvd_in   = {US_PER_MINUTE, (DVD_W-RPM_Q_W)'(0)};
               dvs_in   = prod[DVS_W-1:0];
               rem_in   = '0;
               cnt_in   = RPM_STEPS;
               state_in = ST_DIV_RPM;
            end
         end
         ST_DIV_RPM: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - DIV_CNT_W'(1);
            if (div_last) begin
               rpm_in   = rpm_sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               sync_in     = sync_next;
               rsp_data_in = RSP_DATA_W'({
                  (sync_next ? rpm_ff : RPM_W'(0)),
                  sync_next,
                  tooth_ff,
                  rpm_ff,
                  period_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         teeth_ff     <= TEETH_RESET;
         modulus_ff   <= MODULUS_RESET;
         shift_ff     <= SHIFT_RESET;
         clock_hz_ff  <= CLOCK_RESET;
         prev_ff      <= '0;
         tooth_ff     <= '0;
         sync_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         teeth_ff     <= teeth_in;
         modulus_ff   <= modulus_in;
         shift_ff     <= shift_in;
         clock_hz_ff  <= clock_hz_in;
         prev_ff      <= prev_in;
         tooth_ff     <= tooth_in;
         sync_ff      <= sync_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ticks_ff    <= ticks_in;
      period_ff   <= period_in;
      rpm_ff      <= rpm_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
